@@ rtl/mscrc_pkg.sv @@
package mscrc_pkg;

  localparam int CRC_W = 24;
  localparam int BYTE_W = 8;
  localparam int FIELD5_W = 5;
  localparam int COUNT_W = 4;

  localparam logic [CRC_W-1:0] CRC_GEN = 24'hFFF409;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;
  localparam logic [COUNT_W-1:0] LEN_SHORT = 4'd7;
  localparam logic [COUNT_W-1:0] LEN_LONG = 4'd14;

  // Byte positions within a frame that carry header fields.
  localparam logic [COUNT_W-1:0] POS_FORMAT = 4'd0;
  localparam logic [COUNT_W-1:0] POS_ADDR_HI = 4'd1;
  localparam logic [COUNT_W-1:0] POS_ADDR_MID = 4'd2;
  localparam logic [COUNT_W-1:0] POS_ADDR_LO = 4'd3;
  localparam logic [COUNT_W-1:0] POS_TYPE = 4'd4;

  typedef struct packed {
    logic frame_ok;
    logic length_ok;
    logic [CRC_W-1:0] crc_remainder;
    logic [FIELD5_W-1:0] downlink_format;
    logic [CRC_W-1:0] icao_address;
    logic [FIELD5_W-1:0] type_code;
    logic [COUNT_W-1:0] byte_total;
  } result_t;

  // Eight bit-serial steps of the remainder register, MSB of the byte first.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] rem_in,
                                                input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] rem;
    logic top;
    rem = rem_in;
    for (int k = BYTE_W - 1; k >= 0; k--) begin
      top = rem[CRC_W-1];
      rem = {rem[CRC_W-2:0], data[k]};
      if (top) begin
        rem = rem ^ CRC_GEN;
      end
    end
    return rem;
  endfunction

endpackage

@@ rtl/mscrc_frame_acc.sv @@
module mscrc_frame_acc
  import mscrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              last_byte,
  output result_t           result
);

  logic [CRC_W-1:0]    rem_r, rem_nxt;
  logic [COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic [FIELD5_W-1:0] fmt_r, fmt_nxt;
  logic [CRC_W-1:0]    addr_r, addr_nxt;
  logic [FIELD5_W-1:0] type_r, type_nxt;
  logic                len_ok;

  always_comb begin
    rem_nxt = crc_byte(rem_r, data_byte);
    cnt_nxt = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + 4'd1;
    fmt_nxt = fmt_r;
    addr_nxt = addr_r;
    type_nxt = type_r;
    case (cnt_r)
      POS_FORMAT:   fmt_nxt = data_byte[BYTE_W-1 -: FIELD5_W];
      POS_ADDR_HI:  addr_nxt[23:16] = data_byte;
      POS_ADDR_MID: addr_nxt[15:8] = data_byte;
      POS_ADDR_LO:  addr_nxt[7:0] = data_byte;
      POS_TYPE:     type_nxt = data_byte[BYTE_W-1 -: FIELD5_W];
      default:      ;
    endcase
    len_ok = (cnt_nxt == LEN_SHORT) || (cnt_nxt == LEN_LONG);
    result.frame_ok = len_ok && (rem_nxt == '0);
    result.length_ok = len_ok;
    result.crc_remainder = rem_nxt;
    result.downlink_format = fmt_nxt;
    result.icao_address = addr_nxt;
    result.type_code = type_nxt;
    result.byte_total = cnt_nxt;
  end

  // The whole frame state returns to zero once the marked byte has gone through.
  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      rem_r <= '0;
      cnt_r <= '0;
      fmt_r <= '0;
      addr_r <= '0;
      type_r <= '0;
    end else if (step) begin
      rem_r <= rem_nxt;
      cnt_r <= cnt_nxt;
      fmt_r <= fmt_nxt;
      addr_r <= addr_nxt;
      type_r <= type_nxt;
    end
  end

endmodule

@@ rtl/mode_s_frame_crc_check_core.sv @@
// Mode S frame parity checker. Message bytes enter one per request, most
// significant bit first, with in_last_byte marking the final byte of a frame.
// Each byte is folded into a 24-bit CRC remainder (generator 0xFFF409) while
// the byte count and the header fields (downlink format, 24-bit address and
// type code) are captured. Only the marked byte produces a result request,
// carrying the remainder, the length check (7 or 14 bytes), the pass flag and
// the captured fields; the frame state then clears for the next frame. The
// core takes one byte every clock cycle while no marked byte is held back;
// the eight-bit remainder update lies between the input register and the
// result register, and a marked byte passes the input register and then the
// result register. The result register lets new bytes flow in while a result
// waits to be taken; only a further marked byte stalls behind it.
module mode_s_frame_crc_check_core
  import mscrc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [BYTE_W-1:0]   in_data_byte,
  input  logic                in_last_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_frame_ok,
  output logic                out_length_ok,
  output logic [CRC_W-1:0]    out_crc_remainder,
  output logic [FIELD5_W-1:0] out_downlink_format,
  output logic [CRC_W-1:0]    out_icao_address,
  output logic [FIELD5_W-1:0] out_type_code,
  output logic [COUNT_W-1:0]  out_byte_total
);

  // Input register stage.
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;

  // Result register stage.
  logic    out_valid_r;
  result_t out_res_r;
  result_t acc_res;

  logic out_room;
  logic s1_adv;

  // A byte in the input register moves on at once unless it closes a frame
  // and the result register is still holding an untaken result.
  assign out_room = !out_valid_r || out_ready;
  assign s1_adv = s1_valid_r && (!s1_last_r || out_room);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  mscrc_frame_acc u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_adv),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .result    (acc_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_room) begin
      out_valid_r <= s1_adv && s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_res_r <= acc_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_frame_ok = out_res_r.frame_ok;
  assign out_length_ok = out_res_r.length_ok;
  assign out_crc_remainder = out_res_r.crc_remainder;
  assign out_downlink_format = out_res_r.downlink_format;
  assign out_icao_address = out_res_r.icao_address;
  assign out_type_code = out_res_r.type_code;
  assign out_byte_total = out_res_r.byte_total;

  // A pass is only ever reported with a good length and a zero remainder.
  a_frame_ok_rule: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.frame_ok ==
                     (out_res_r.length_ok && (out_res_r.crc_remainder == '0))))
    else $error("frame_ok disagrees with length and remainder");

  // The length flag must match the reported byte count.
  a_length_rule: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.length_ok ==
                     ((out_res_r.byte_total == LEN_SHORT) ||
                      (out_res_r.byte_total == LEN_LONG))))
    else $error("length_ok disagrees with byte_total");

  // The input side only stalls behind a held marked byte.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s1_last_r && out_valid_r && !out_ready))
    else $error("input stalled without a blocked frame end");

  // A frame end that moves on always lands in the result register.
  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> out_valid_r)
    else $error("frame end lost between stages");

endmodule

@@ dv/mode_s_frame_crc_check_core_tb.sv @@
module mode_s_frame_crc_check_core_tb
  import mscrc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // One line of the directed stimulus. Where 'given' is set, the report that
  // the byte closes is typed into the row and stands as the expectation;
  // every other row is checked against the predictor alone.
  typedef struct packed {
    logic          last;
    logic [7:0]    data;
    logic          given;
    result_t       rep;
  } row_t;

  localparam int TABLE_LEN    = 28;
  localparam int RANDOM_ITEMS = 1850;
  localparam int CYCLE_LIMIT  = 800000;
  // Cycles waited after the queue of awaited reports has emptied, before it is checked once more.
  localparam int DRAIN_CYCLES = 8;
  localparam result_t NO_REPORT = '0;

  // The directed part: a lone zero byte, a lone all-ones byte, a short
  // three-byte frame whose address is only partly delivered, a seven-byte
  // all-zero frame that must pass, and a sixteen-byte all-ones frame that
  // drives the byte count into saturation.
  localparam row_t STIM_TABLE [TABLE_LEN] = '{
    '{1'b1, 8'h00, 1'b1, '{1'b0, 1'b0, 24'h000000, 5'h00, 24'h000000, 5'h00, 4'd1}},
    '{1'b1, 8'hFF, 1'b1, '{1'b0, 1'b0, 24'h0000FF, 5'h1F, 24'h000000, 5'h00, 4'd1}},
    '{1'b0, 8'hA8, 1'b0, NO_REPORT},
    '{1'b0, 8'h12, 1'b0, NO_REPORT},
    '{1'b1, 8'h34, 1'b1, '{1'b0, 1'b0, 24'hA81234, 5'h15, 24'h123400, 5'h00, 4'd3}},
    '{1'b0, 8'h00, 1'b0, NO_REPORT},
    '{1'b0, 8'h00, 1'b0, NO_REPORT},
    '{1'b0, 8'h00, 1'b0, NO_REPORT},
    '{1'b0, 8'h00, 1'b0, NO_REPORT},
    '{1'b0, 8'h00, 1'b0, NO_REPORT},
    '{1'b0, 8'h00, 1'b0, NO_REPORT},
    '{1'b1, 8'h00, 1'b1, '{1'b1, 1'b1, 24'h000000, 5'h00, 24'h000000, 5'h00, 4'd7}},
    '{1'b0, 8'hFF, 1'b0, NO_REPORT},
    '{1'b0, 8'hFF, 1'b0, NO_REPORT},
    '{1'b0, 8'hFF, 1'b0, NO_REPORT},
    '{1'b0, 8'hFF, 1'b0, NO_REPORT},
    '{1'b0, 8'hFF, 1'b0, NO_REPORT},
    '{1'b0, 8'hFF, 1'b0, NO_REPORT},
    '{1'b0, 8'hFF, 1'b0, NO_REPORT},
    '{1'b0, 8'hFF, 1'b0, NO_REPORT},
    '{1'b0, 8'hFF, 1'b0, NO_REPORT},
    '{1'b0, 8'hFF, 1'b0, NO_REPORT},
    '{1'b0, 8'hFF, 1'b0, NO_REPORT},
    '{1'b0, 8'hFF, 1'b0, NO_REPORT},
    '{1'b0, 8'hFF, 1'b0, NO_REPORT},
    '{1'b0, 8'hFF, 1'b0, NO_REPORT},
    '{1'b0, 8'hFF, 1'b0, NO_REPORT},
    '{1'b1, 8'hFF, 1'b0, NO_REPORT}
  };

  // Every input of the block holds a known value from time zero.
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [BYTE_W-1:0]   in_data_byte = '0;
  logic                in_last_byte = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_frame_ok;
  logic                out_length_ok;
  logic [CRC_W-1:0]    out_crc_remainder;
  logic [FIELD5_W-1:0] out_downlink_format;
  logic [CRC_W-1:0]    out_icao_address;
  logic [FIELD5_W-1:0] out_type_code;
  logic [COUNT_W-1:0]  out_byte_total;

  // The predictor's own copy of the frame state.
  logic [CRC_W-1:0]    frame_rem = '0;
  logic [COUNT_W-1:0]  frame_count = '0;
  logic [FIELD5_W-1:0] frame_format = '0;
  logic [CRC_W-1:0]    frame_address = '0;
  logic [FIELD5_W-1:0] frame_type = '0;

  // Rows presented to the block, in order, and the reports still awaited.
  row_t    offered_rows [$];
  result_t awaited_reports [$];

  int  cycle_count = 0;
  int  error_count = 0;
  int  bytes_sent = 0;
  int  frames_sent = 0;
  int  reports_checked = 0;
  int  passing_reports = 0;
  int  saturated_reports = 0;
  int  stall_left = 0;
  bit  calm_phase = 1'b0;

  mode_s_frame_crc_check_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_last_byte        (in_last_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_frame_ok        (out_frame_ok),
    .out_length_ok       (out_length_ok),
    .out_crc_remainder   (out_crc_remainder),
    .out_downlink_format (out_downlink_format),
    .out_icao_address    (out_icao_address),
    .out_type_code       (out_type_code),
    .out_byte_total      (out_byte_total)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Divides the message bit stream by the generator: each bit enters at the
  // bottom of the register, and whatever falls out of the top decides whether
  // the generator is folded back in.
  function automatic logic [CRC_W-1:0] fold_byte(logic [CRC_W-1:0] rem,
                                                 logic [BYTE_W-1:0] data);
    logic spill;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      spill = rem[CRC_W-1];
      rem = {rem[CRC_W-2:0], data[i]} ^ (spill ? CRC_GEN : '0);
    end
    return rem;
  endfunction

  // Advances the predicted frame state by one accepted byte. A marked byte
  // closes the frame, yields the report and clears the state again.
  task automatic absorb_byte(input logic [BYTE_W-1:0] data, input logic last,
                             output bit produced, output result_t rep);
    logic [COUNT_W-1:0] position;
    logic length_good;
    position = frame_count;
    frame_rem = fold_byte(frame_rem, data);
    case (position)
      POS_FORMAT:   frame_format = data[7:3];
      POS_ADDR_HI:  frame_address[23:16] = data;
      POS_ADDR_MID: frame_address[15:8] = data;
      POS_ADDR_LO:  frame_address[7:0] = data;
      POS_TYPE:     frame_type = data[7:3];
      default: ;
    endcase
    // The count stops at its ceiling, though later bytes still reach the
    // remainder.
    if (frame_count != COUNT_MAX) begin
      frame_count = frame_count + 4'd1;
    end
    produced = last;
    rep = '0;
    if (last) begin
      length_good = (frame_count == LEN_SHORT) || (frame_count == LEN_LONG);
      rep.frame_ok = length_good && (frame_rem == '0);
      rep.length_ok = length_good;
      rep.crc_remainder = frame_rem;
      rep.downlink_format = frame_format;
      rep.icao_address = frame_address;
      rep.type_code = frame_type;
      rep.byte_total = frame_count;
      frame_rem = '0;
      frame_count = '0;
      frame_format = '0;
      frame_address = '0;
      frame_type = '0;
    end
  endtask

  function automatic string describe(result_t r);
    return $sformatf("ok=%0b len_ok=%0b rem=%06h df=%0d aa=%06h tc=%0d bytes=%0d",
                     r.frame_ok, r.length_ok, r.crc_remainder, r.downlink_format,
                     r.icao_address, r.type_code, r.byte_total);
  endfunction

  // Only the first ten failures are shown in full; the rest are counted.
  task automatic log_failure(input string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  // Mostly short pauses, now and then a long one.
  function automatic int gap_length();
    if ($urandom_range(0, 19) == 0) begin
      return $urandom_range(8, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  // The idling pattern switches between calm stretches, in which neither
  // side pauses, and busy stretches with random gaps on both sides.
  always begin
    repeat ($urandom_range(150, 600)) @(posedge clk);
    calm_phase <= !calm_phase;
  end

  // Result side: random back-pressure, so that reports wait in the result
  // register while further bytes are still flowing in.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!calm_phase && $urandom_range(0, 99) < 25) begin
        stall_left <= gap_length();
      end
    end
  end

  // Input monitor: every accepted byte goes through the predictor, and a
  // marked byte leaves its report in the queue of awaited reports. A typed
  // report from the directed table takes the predictor's place.
  always @(posedge clk) begin : take_byte
    row_t    row;
    bit      produced;
    result_t rep;
    if (rst_n && in_valid && in_ready) begin
      row = offered_rows.pop_front();
      absorb_byte(in_data_byte, in_last_byte, produced, rep);
      if (produced) begin
        if (row.given) begin
          rep = row.rep;
        end
        awaited_reports = {awaited_reports, rep};
      end
    end
  end

  // Result monitor: each accepted report is compared, field by field, with
  // the oldest awaited one.
  always @(posedge clk) begin : check_report
    result_t got;
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_frame_ok, out_length_ok, out_crc_remainder, out_downlink_format,
             out_icao_address, out_type_code, out_byte_total};
      if (awaited_reports.size() == 0) begin
        log_failure($sformatf("tb: report with none awaited: %s", describe(got)));
      end else begin
        want = awaited_reports.pop_front();
        reports_checked++;
        if (got.frame_ok)      passing_reports++;
        if (got.byte_total == COUNT_MAX) saturated_reports++;
        if (got.frame_ok !== want.frame_ok ||
            got.length_ok !== want.length_ok ||
            got.crc_remainder !== want.crc_remainder ||
            got.downlink_format !== want.downlink_format ||
            got.icao_address !== want.icao_address ||
            got.type_code !== want.type_code ||
            got.byte_total !== want.byte_total) begin
          log_failure($sformatf("tb: report %0d mismatch: expected %s, got %s",
                                reports_checked, describe(want), describe(got)));
        end
      end
    end
  end

  // Presents one byte as a request and holds it until it is accepted. A gap,
  // where one is drawn, drops the valid first; otherwise the valid stays high
  // straight into the next request.
  task automatic send_request(input row_t row);
    int gap;
    gap = 0;
    if (!calm_phase && $urandom_range(0, 99) < 40) begin
      gap = gap_length();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= row.data;
    in_last_byte <= row.last;
    offered_rows = {offered_rows, row};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    if (row.last) begin
      frames_sent++;
    end
  endtask

  // Watchdog: a run that never drains ends here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [BYTE_W-1:0] frame_bytes [24];
    logic [CRC_W-1:0]  parity;
    row_t              row;
    int                len;
    int                pick;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < TABLE_LEN; i++) begin
      send_request(STIM_TABLE[i]);
    end

    // Random frames. Most are well formed, seven or fourteen bytes with the
    // parity bytes computed so that the frame passes; some of those have a
    // single bit flipped, and the rest are frames of random length and
    // content, now and then long enough to saturate the byte count.
    while (bytes_sent < TABLE_LEN + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        len = ($urandom_range(0, 1) == 0) ? int'(LEN_SHORT) : int'(LEN_LONG);
        parity = '0;
        for (int i = 0; i < len - 3; i++) begin
          frame_bytes[i] = 8'($urandom_range(0, 255));
          parity = fold_byte(parity, frame_bytes[i]);
        end
        // Feeding three zero bytes leaves the parity that cancels the
        // remainder of the message part.
        repeat (3) parity = fold_byte(parity, 8'h00);
        frame_bytes[len-3] = parity[23:16];
        frame_bytes[len-2] = parity[15:8];
        frame_bytes[len-1] = parity[7:0];
        if (pick >= 60) begin
          frame_bytes[$urandom_range(0, len - 1)] ^= 8'h01 << $urandom_range(0, 7);
        end
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 22) : $urandom_range(1, 14);
        for (int i = 0; i < len; i++) begin
          frame_bytes[i] = 8'($urandom_range(0, 255));
        end
      end
      for (int i = 0; i < len; i++) begin
        row = '0;
        row.data = frame_bytes[i];
        row.last = (i == len - 1);
        send_request(row);
      end
    end

    in_valid <= 1'b0;
    // Let the input monitor record the final byte before the queue is read.
    @(posedge clk);
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_reports.size() != 0) begin
      log_failure($sformatf("tb: %0d reports never arrived", awaited_reports.size()));
    end

    $display("tb: %0d bytes in %0d frames, %0d reports checked", bytes_sent, frames_sent,
             reports_checked);
    $display("tb: %0d reports passed parity, %0d saturated the byte count, %0d failures",
             passing_reports, saturated_reports, error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
